// ===== sv/dva_pkg.sv =====
package dva_pkg;

   localparam int NUM_VOICES = 64;
   localparam int NUM_BANDS  = 24;

   localparam int VIDX_W  = $clog2(NUM_VOICES);
   localparam int BIDX_W  = $clog2(NUM_BANDS);
   localparam int LIVE_W  = $clog2(NUM_VOICES + 1);
   localparam int SPAWN_W = $clog2(NUM_BANDS + 1);

   localparam int OP_W        = 2;
   localparam int BAND_IN_W   = 5;
   localparam int AMP_W       = 20;
   localparam int STRIDE_W    = 6;
   localparam int TRAIL_W     = 16;
   localparam int VINDEX_W    = 6;
   localparam int BAND_W      = 6;
   localparam int PHASE_W     = 24;
   localparam int LIVE_OUT_W  = 7;
   localparam int SPAWN_OUT_W = 5;
   localparam int FLOOR_W     = 16;
   localparam int SEED_W      = 32;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 64;

   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 21;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic [SEED_W-1:0]  LCG_MUL           = 32'd1664525;
   localparam logic [SEED_W-1:0]  LCG_ADD           = 32'd1013904223;
   localparam logic [SEED_W-1:0]  LCG_RESET         = 32'h2545F491;
   localparam logic [FLOOR_W-1:0] AMP_FLOOR_RESET   = 16'd7;
   localparam logic [FLOOR_W-1:0] SPAWN_FLOOR_RESET = 16'd66;

   typedef enum logic [OP_W-1:0] {
      OP_OFFER = 2'd0,
      OP_TICK  = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic {
      CSR_AMP_FLOOR   = 1'b0,
      CSR_SPAWN_FLOOR = 1'b1
   } csr_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [BAND_W-1:0]  band;
      logic [AMP_W-1:0]   amp;
   } slot_type;

   typedef struct packed {
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

endpackage

// ===== sv/dva_mul.sv =====
module dva_mul (
   input  logic                          clock,
   input  dva_pkg::mul_req_type          mul_req,
   output logic [dva_pkg::MUL_P_W-1:0]   mul_p_ff
);
   import dva_pkg::*;

   // shared registered multiplier: amplitude decay and lcg step
   always_ff @(posedge clock) begin
      mul_p_ff <= MUL_P_W'(mul_req.a) * MUL_P_W'(mul_req.b);
   end

endmodule

// ===== sv/decaying_voice_allocator.sv =====
// Voice allocator with decaying amplitudes. An offer transfer (operation 0) peak-holds
// a level into one pending band. A read transfer (operation 2) returns one slot.
// A tick transfer (operation 1) runs a sequencer around one slot memory with one read
// port and one write port and one shared registered multiplier: aging reads, scales
// and writes back each live slot and skips free ones, then with a nonzero stride each
// band whose pending level reaches the spawn floor scans the slots and spawns a voice.
// Ticks and reads each produce one result transfer; offers and operation 3 produce none.
// The block takes no request while a tick or read is in progress, and a finished
// result waits in the output register while the next request is taken.
module decaying_voice_allocator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // band[4:0], rise_level[24:5], stride[30:25], trail[46:31], voice_index[52:47]
   input  logic [dva_pkg::REQ_DATA_W-1:0]     req_tdata,
   // operation[1:0]
   input  logic [dva_pkg::OP_W-1:0]           req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // voice_live[0], voice_band[6:1], voice_level[26:7], voice_phase[50:27],
   // live_count[57:51], spawned_count[62:58]
   output logic [dva_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_wen,
   input  logic                               csr_index,
   input  logic [dva_pkg::FLOOR_W-1:0]        csr_wdata
);
   import dva_pkg::*;

   localparam logic signed [BAND_W:0] BAND_LO = -(BAND_W+1)'(2);
   localparam logic signed [BAND_W:0] BAND_HI = (BAND_W+1)'(NUM_BANDS - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_AGE_RD, S_AGE_MUL, S_AGE_WR, S_PEND, S_SCAN, S_SCAN_LAST,
      S_SEED_MUL, S_SPAWN_WR, S_READ_RD, S_READ_OUT, S_RESULT
   } state_type;

   state_type state_ff;

   logic [NUM_VOICES-1:0]     active_ff;
   logic [LIVE_W-1:0]         live_ff;
   logic [SPAWN_W-1:0]        spawned_ff;
   logic [AMP_W-1:0]          pend_ff [NUM_BANDS];
   logic [SEED_W-1:0]         seed_ff;
   logic [FLOOR_W-1:0]        amp_floor_ff;
   logic [FLOOR_W-1:0]        spawn_floor_ff;

   logic [STRIDE_W-1:0]       stride_ff;
   logic [TRAIL_W-1:0]        trail_ff;
   logic [VINDEX_W-1:0]       vidx_ff;
   logic [VIDX_W-1:0]         voice_ff;
   logic [BIDX_W-1:0]         k_ff;
   logic [AMP_W-1:0]          level_ff;
   logic [VIDX_W-1:0]         scan_ff;
   logic [VIDX_W-1:0]         cmp_idx_ff;
   logic                      cmp_valid_ff;
   logic [AMP_W-1:0]          least_ff;
   logic [VIDX_W-1:0]         best_ff;
   logic [VIDX_W-1:0]         pick_ff;
   logic                      pick_free_ff;

   logic                      res_live_ff;
   logic [BAND_W-1:0]         res_band_ff;
   logic [AMP_W-1:0]          res_level_ff;
   logic [PHASE_W-1:0]        res_phase_ff;

   logic                      rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]     rsp_tdata_ff;

   slot_type                  slot_mem [NUM_VOICES];
   slot_type                  rdata_ff;

   // request fields
   op_type                    req_op;
   logic [BAND_IN_W-1:0]      req_band;
   logic [AMP_W-1:0]          req_rise;
   logic [STRIDE_W-1:0]       req_stride;
   logic [TRAIL_W-1:0]        req_trail;
   logic [VINDEX_W-1:0]       req_vidx;

   logic                      mem_we;
   logic [VIDX_W-1:0]         mem_wa;
   logic [VIDX_W-1:0]         mem_ra;
   slot_type                  mem_wd;
   mul_req_type               mul_req;
   logic [MUL_P_W-1:0]        mul_p;

   logic [BIDX_W-1:0]         pend_addr;
   logic [AMP_W-1:0]          pend_rd;
   logic [AMP_W-1:0]          amp_new;
   logic signed [BAND_W:0]    band_sum;
   logic                      kill;
   logic [AMP_W-1:0]          cand_least;
   logic [VIDX_W-1:0]         cand_best;
   logic [SEED_W-1:0]         seed_next;
   logic                      voice_last;
   logic                      k_last;
   logic                      scan_last;
   logic                      vidx_ok;
   state_type                 age_exit;

   assign req_op     = op_type'(req_tuser);
   assign req_band   = req_tdata[4:0];
   assign req_rise   = req_tdata[24:5];
   assign req_stride = req_tdata[30:25];
   assign req_trail  = req_tdata[46:31];
   assign req_vidx   = req_tdata[52:47];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign voice_last = (voice_ff == VIDX_W'(NUM_VOICES - 1));
   assign scan_last  = (scan_ff == VIDX_W'(NUM_VOICES - 1));
   assign k_last     = (k_ff == BIDX_W'(NUM_BANDS - 1));
   assign vidx_ok    = (32'(vidx_ff) < NUM_VOICES);
   assign age_exit   = (stride_ff != '0) ? S_PEND : S_RESULT;

   assign pend_addr = (state_ff == S_IDLE) ? BIDX_W'(req_band) : k_ff;
   assign pend_rd   = pend_ff[pend_addr];

   dva_mul u_mul (
      .clock    (clock),
      .mul_req  (mul_req),
      .mul_p_ff (mul_p)
   );

   always_comb begin
      mul_req.a = MUL_A_W'(rdata_ff.amp);
      mul_req.b = MUL_B_W'(trail_ff);
      if (state_ff == S_SEED_MUL) begin
         mul_req.a = seed_ff;
         mul_req.b = MUL_B_W'(LCG_MUL);
      end

      amp_new  = mul_p[AMP_W+TRAIL_W-1:TRAIL_W];
      band_sum = $signed({rdata_ff.band[BAND_W-1], rdata_ff.band})
               + $signed({stride_ff[STRIDE_W-1], stride_ff});
      kill     = (amp_new < AMP_W'(amp_floor_ff)) || (band_sum < BAND_LO)
               || (band_sum > BAND_HI);

      seed_next = mul_p[SEED_W-1:0] + LCG_ADD;

      // running minimum over the slot already read out of memory
      cand_least = least_ff;
      cand_best  = best_ff;
      if (cmp_valid_ff && (rdata_ff.amp < least_ff)) begin
         cand_least = rdata_ff.amp;
         cand_best  = cmp_idx_ff;
      end

      unique case (state_ff)
         S_SCAN:    mem_ra = scan_ff;
         S_READ_RD: mem_ra = VIDX_W'(vidx_ff);
         default:   mem_ra = voice_ff;
      endcase

      mem_we = (state_ff == S_AGE_WR) || (state_ff == S_SPAWN_WR);
      if (state_ff == S_SPAWN_WR) begin
         mem_wa       = pick_ff;
         mem_wd.phase = seed_next[SEED_W-1:SEED_W-PHASE_W];
         mem_wd.band  = BAND_W'(k_ff);
         mem_wd.amp   = level_ff;
      end else begin
         mem_wa       = voice_ff;
         mem_wd.phase = rdata_ff.phase;
         mem_wd.band  = band_sum[BAND_W-1:0];
         mem_wd.amp   = amp_new;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= slot_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         active_ff      <= '0;
         live_ff        <= '0;
         spawned_ff     <= '0;
         seed_ff        <= LCG_RESET;
         amp_floor_ff   <= AMP_FLOOR_RESET;
         spawn_floor_ff <= SPAWN_FLOOR_RESET;
         rsp_tvalid_ff  <= 1'b0;
         cmp_valid_ff   <= 1'b0;
         pick_free_ff   <= 1'b0;
         for (int b = 0; b < NUM_BANDS; b++) begin
            pend_ff[b] <= '0;
         end
      end else begin
         if (csr_wen) begin
            unique case (csr_type'(csr_index))
               CSR_AMP_FLOOR:   amp_floor_ff   <= csr_wdata;
               CSR_SPAWN_FLOOR: spawn_floor_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (rsp_tvalid_ff && rsp_tready && (state_ff != S_RESULT)) begin
            rsp_tvalid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  unique case (req_op)
                     OP_OFFER: begin
                        if ((32'(req_band) < NUM_BANDS) && (req_rise > pend_rd)) begin
                           pend_ff[pend_addr] <= req_rise;
                        end
                     end
                     OP_TICK: begin
                        stride_ff    <= req_stride;
                        trail_ff     <= req_trail;
                        voice_ff     <= '0;
                        k_ff         <= '0;
                        spawned_ff   <= '0;
                        res_live_ff  <= 1'b0;
                        res_band_ff  <= '0;
                        res_level_ff <= '0;
                        res_phase_ff <= '0;
                        state_ff     <= S_AGE_RD;
                     end
                     OP_READ: begin
                        vidx_ff    <= req_vidx;
                        spawned_ff <= '0;
                        state_ff   <= S_READ_RD;
                     end
                     default: ;
                  endcase
               end
            end
            S_AGE_RD: begin
               if (active_ff[voice_ff]) begin
                  state_ff <= S_AGE_MUL;
               end else if (voice_last) begin
                  state_ff <= age_exit;
               end else begin
                  voice_ff <= voice_ff + 1'b1;
               end
            end
            S_AGE_MUL: begin
               state_ff <= S_AGE_WR;
            end
            S_AGE_WR: begin
               if (kill) begin
                  active_ff[voice_ff] <= 1'b0;
                  live_ff             <= live_ff - 1'b1;
               end
               if (voice_last) begin
                  state_ff <= age_exit;
               end else begin
                  voice_ff <= voice_ff + 1'b1;
                  state_ff <= S_AGE_RD;
               end
            end
            S_PEND: begin
               pend_ff[k_ff] <= '0;
               if (pend_rd >= AMP_W'(spawn_floor_ff)) begin
                  level_ff     <= pend_rd;
                  scan_ff      <= '0;
                  cmp_valid_ff <= 1'b0;
                  least_ff     <= '1;
                  best_ff      <= '0;
                  state_ff     <= S_SCAN;
               end else if (k_last) begin
                  state_ff <= S_RESULT;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            S_SCAN: begin
               least_ff <= cand_least;
               best_ff  <= cand_best;
               if (!active_ff[scan_ff]) begin
                  // first free slot wins outright
                  pick_ff      <= scan_ff;
                  pick_free_ff <= 1'b1;
                  state_ff     <= S_SEED_MUL;
               end else begin
                  cmp_idx_ff   <= scan_ff;
                  cmp_valid_ff <= 1'b1;
                  if (scan_last) begin
                     state_ff <= S_SCAN_LAST;
                  end else begin
                     scan_ff <= scan_ff + 1'b1;
                  end
               end
            end
            S_SCAN_LAST: begin
               pick_ff      <= cand_best;
               pick_free_ff <= 1'b0;
               state_ff     <= S_SEED_MUL;
            end
            S_SEED_MUL: begin
               state_ff <= S_SPAWN_WR;
            end
            S_SPAWN_WR: begin
               seed_ff            <= seed_next;
               active_ff[pick_ff] <= 1'b1;
               if (pick_free_ff) begin
                  live_ff <= live_ff + 1'b1;
               end
               spawned_ff <= spawned_ff + 1'b1;
               if (k_last) begin
                  state_ff <= S_RESULT;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_PEND;
               end
            end
            S_READ_RD: begin
               state_ff <= S_READ_OUT;
            end
            S_READ_OUT: begin
               if (vidx_ok && active_ff[VIDX_W'(vidx_ff)]) begin
                  res_live_ff  <= 1'b1;
                  res_band_ff  <= rdata_ff.band;
                  res_level_ff <= rdata_ff.amp;
                  res_phase_ff <= rdata_ff.phase;
               end else begin
                  res_live_ff  <= 1'b0;
                  res_band_ff  <= '0;
                  res_level_ff <= '0;
                  res_phase_ff <= '0;
               end
               state_ff <= S_RESULT;
            end
            S_RESULT: begin
               // hold until the output register is free
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {1'b0, SPAWN_OUT_W'(spawned_ff), LIVE_OUT_W'(live_ff),
                                    res_phase_ff, res_level_ff, res_band_ff, res_live_ff};
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_live_matches_active: assert property (@(posedge clock) disable iff (reset)
      32'(live_ff) == $countones(active_ff))
      else $error("live count out of step with active slots");

   a_free_pick_is_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SPAWN_WR) && pick_free_ff |-> !active_ff[pick_ff])
      else $error("free-slot spawn landed on a live slot");

   a_spawn_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(spawned_ff) <= NUM_BANDS)
      else $error("more spawns than bands in one tick");

   a_steal_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SPAWN_WR) && !pick_free_ff |-> (32'(live_ff) == NUM_VOICES))
      else $error("voice stolen while a slot was free");
`endif

endmodule

// ===== dv/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dva_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int TRAIL_MAX     = 64225;
   localparam int STRIDE_MAX    = 23;
   localparam int BAND_LOW      = -2;
   localparam int MAX_WAIT      = 16;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 12;
   localparam int IDLE_LIMIT    = 12000;
   localparam int BATCH_ITEMS   = 29;
   localparam int FLOOR_PLANS   = 5;
   localparam int PRINT_LIMIT   = 100;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [BAND_IN_W-1:0] band;
      logic [AMP_W-1:0]     rise;
      logic [STRIDE_W-1:0]  stride;
      logic [TRAIL_W-1:0]   trail;
      logic [VINDEX_W-1:0]  vidx;
   } voice_request;

   typedef struct packed {
      logic                   live;
      logic [BAND_W-1:0]      band;
      logic [AMP_W-1:0]       level;
      logic [PHASE_W-1:0]     phase;
      logic [LIVE_OUT_W-1:0]  live_count;
      logic [SPAWN_OUT_W-1:0] spawned;
   } voice_report;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wen    = 1'b0;
   logic                  csr_index  = 1'b0;
   logic [FLOOR_W-1:0]    csr_wdata  = '0;

   decaying_voice_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // voice bank mirror
   logic               voice_on    [NUM_VOICES];
   int                 voice_pos   [NUM_VOICES];
   logic [AMP_W-1:0]   voice_amp   [NUM_VOICES];
   logic [PHASE_W-1:0] voice_start [NUM_VOICES];
   logic [AMP_W-1:0]   band_peak   [NUM_BANDS];
   logic [SEED_W-1:0]  phase_seed;
   logic [FLOOR_W-1:0] amp_floor;
   logic [FLOOR_W-1:0] spawn_floor;

   voice_request queued_requests[$];
   voice_report  pending_voice_reports[$];
   voice_request current_request;

   int counted_items = 0;
   int mismatches    = 0;
   int results_seen  = 0;
   int offers_seen   = 0;
   int ticks_seen    = 0;
   int reads_seen    = 0;
   int ignored_seen  = 0;
   int spawned_seen  = 0;
   int steals_seen   = 0;
   int peak_live     = 0;
   int idle_cycles   = 0;

   int send_wait      = 0;
   int send_run_left  = 0;
   bit send_run_busy  = 1'b0;
   int take_wait      = 0;
   int take_run_left  = 0;
   bit take_run_busy  = 1'b0;
   int hold_left      = 0;
   int holds_asked    = 0;
   int holds_served   = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
      // keep the log readable when everything goes wrong
      if (mismatches < PRINT_LIMIT)
         $display("mismatch at result %0d: %s got %0h expected %0h",
                  results_seen, what, got, want);
      mismatches++;
   endtask

   function automatic int draw_wait(inout int run_left, inout bit run_busy);
      if (run_left == 0) begin
         run_left = $urandom_range(8, 40);
         run_busy = ($urandom_range(0, 2) == 0);
      end
      run_left--;
      return run_busy ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic int live_voices();
      int n = 0;
      for (int i = 0; i < NUM_VOICES; i++)
         if (voice_on[i]) n++;
      return n;
   endfunction

   // first free slot, else the quietest with the lowest index on a tie
   function automatic int choose_slot();
      int         quietest = 0;
      logic [AMP_W:0] least = '1;
      for (int i = 0; i < NUM_VOICES; i++) begin
         if (!voice_on[i]) return i;
         if ({1'b0, voice_amp[i]} < least) begin
            least    = {1'b0, voice_amp[i]};
            quietest = i;
         end
      end
      steals_seen++;
      return quietest;
   endfunction

   function automatic bit advance_voice_bank(input voice_request rq, output voice_report rep);
      logic [AMP_W+TRAIL_W-1:0] scaled;
      int slot;
      int live;
      int spawned = 0;
      rep = '0;
      case (rq.op)
         OP_OFFER: begin
            if (int'(rq.band) < NUM_BANDS) begin
               offers_seen++;
               if (rq.rise > band_peak[rq.band]) band_peak[rq.band] = rq.rise;
            end else begin
               ignored_seen++;
            end
            return 1'b0;
         end
         OP_TICK: begin
            ticks_seen++;
            for (int i = 0; i < NUM_VOICES; i++) begin
               if (voice_on[i]) begin
                  voice_pos[i] += int'($signed(rq.stride));
                  scaled = (AMP_W+TRAIL_W)'(voice_amp[i]) * (AMP_W+TRAIL_W)'(rq.trail);
                  voice_amp[i] = scaled[AMP_W+TRAIL_W-1:TRAIL_W];
                  if (voice_amp[i] < AMP_W'(amp_floor) || voice_pos[i] < BAND_LOW ||
                      voice_pos[i] > NUM_BANDS - 1)
                     voice_on[i] = 1'b0;
               end
            end
            // zero stride keeps the pending levels for a later tick
            if (rq.stride != '0) begin
               for (int k = 0; k < NUM_BANDS; k++) begin
                  if (band_peak[k] >= AMP_W'(spawn_floor)) begin
                     slot = choose_slot();
                     phase_seed         = phase_seed * LCG_MUL + LCG_ADD;
                     voice_on[slot]     = 1'b1;
                     voice_amp[slot]    = band_peak[k];
                     voice_pos[slot]    = k;
                     voice_start[slot]  = phase_seed[SEED_W-1:SEED_W-PHASE_W];
                     spawned++;
                  end
                  band_peak[k] = '0;
               end
            end
            live           = live_voices();
            rep.live_count = LIVE_OUT_W'(live);
            rep.spawned    = SPAWN_OUT_W'(spawned);
            spawned_seen  += spawned;
            if (live > peak_live) peak_live = live;
            return 1'b1;
         end
         OP_READ: begin
            reads_seen++;
            if (voice_on[rq.vidx]) begin
               rep.live  = 1'b1;
               rep.band  = voice_pos[rq.vidx][BAND_W-1:0];
               rep.level = voice_amp[rq.vidx];
               rep.phase = voice_start[rq.vidx];
            end
            rep.live_count = LIVE_OUT_W'(live_voices());
            return 1'b1;
         end
         default: begin
            ignored_seen++;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic logic [STRIDE_W-1:0] any_stride();
      return STRIDE_W'(int'($urandom_range(0, 2 * STRIDE_MAX)) - STRIDE_MAX);
   endfunction

   function automatic logic [TRAIL_W-1:0] any_trail();
      return TRAIL_W'($urandom_range(0, TRAIL_MAX));
   endfunction

   task automatic queue_item(logic [OP_W-1:0] op, logic [BAND_IN_W-1:0] band,
                             logic [AMP_W-1:0] rise, logic [STRIDE_W-1:0] stride,
                             logic [TRAIL_W-1:0] trail, logic [VINDEX_W-1:0] vidx);
      voice_request rq;
      rq = '{op: op, band: band, rise: rise, stride: stride, trail: trail, vidx: vidx};
      queued_requests.push_back(rq);
      if (op != OP_UNUSED && !(op == OP_OFFER && int'(band) >= NUM_BANDS)) counted_items++;
   endtask

   // a burst of offers, one tick, then a few reads of the bank
   task automatic queue_frame();
      int offers;
      logic [AMP_W-1:0] level;
      logic [STRIDE_W-1:0] step;
      logic [TRAIL_W-1:0] keep;
      offers = $urandom_range(0, 16);
      for (int n = 0; n < offers; n++) begin
         case ($urandom_range(0, 2))
            0: level = AMP_W'($urandom);
            1: level = AMP_W'(32'(spawn_floor) + $urandom_range(0, 4) - 2);
            default: level = AMP_W'($urandom_range(0, 'h1FFFF));
         endcase
         queue_item(OP_OFFER, BAND_IN_W'($urandom_range(0, NUM_BANDS - 1)), level,
                    any_stride(), any_trail(), VINDEX_W'($urandom));
      end
      case ($urandom_range(0, 9))
         0: step = '0;
         1: step = any_stride();
         default: step = STRIDE_W'($urandom_range(0, 1) ? int'($urandom_range(1, 3))
                                                        : -int'($urandom_range(1, 3)));
      endcase
      keep = ($urandom_range(0, 3) == 0) ? any_trail()
                                          : TRAIL_W'($urandom_range(50000, TRAIL_MAX));
      queue_item(OP_TICK, BAND_IN_W'($urandom), AMP_W'($urandom), step, keep,
                 VINDEX_W'($urandom));
      repeat ($urandom_range(1, 4))
         queue_item(OP_READ, BAND_IN_W'($urandom), AMP_W'($urandom), any_stride(),
                    any_trail(), VINDEX_W'($urandom_range(0, NUM_VOICES - 1)));
   endtask

   task automatic queue_batch(int target);
      int stop_at;
      stop_at = counted_items + target;
      while (counted_items < stop_at) begin
         if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 4))
               queue_item(OP_W'($urandom), BAND_IN_W'($urandom), AMP_W'($urandom),
                          any_stride(), any_trail(), VINDEX_W'($urandom));
         end else begin
            queue_frame();
         end
      end
   endtask

   task automatic wait_until_drained();
      do @(negedge clock);
      while (queued_requests.size() != 0 || req_tvalid || pending_voice_reports.size() != 0);
      // offers give no result, let the last one settle
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_floors(logic [FLOOR_W-1:0] amp_value, logic [FLOOR_W-1:0] spawn_value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= CSR_AMP_FLOOR;
      csr_wdata <= amp_value;
      amp_floor  = amp_value;
      @(posedge clock);
      csr_index <= CSR_SPAWN_FLOOR;
      csr_wdata <= spawn_value;
      spawn_floor = spawn_value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      @(negedge clock);
   endtask

   always @(posedge clock) begin : drive_requests
      voice_report rep;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (advance_voice_bank(current_request, rep)) pending_voice_reports.push_back(rep);
         end
         if (!req_tvalid || req_tready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_tvalid <= 1'b0;
            end else if (queued_requests.size() != 0) begin
               current_request = queued_requests.pop_front();
               req_tuser  <= current_request.op;
               req_tdata  <= {3'b000, current_request.vidx, current_request.trail,
                              current_request.stride, current_request.rise,
                              current_request.band};
               req_tvalid <= 1'b1;
               send_wait   = draw_wait(send_run_left, send_run_busy);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      voice_report want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (pending_voice_reports.size() == 0) begin
               flag_mismatch("result with nothing outstanding", rsp_tdata, '0);
            end else begin
               want = pending_voice_reports.pop_front();
               if (rsp_tdata[0] !== want.live)
                  flag_mismatch("voice_live", 64'(rsp_tdata[0]), 64'(want.live));
               if (rsp_tdata[6:1] !== want.band)
                  flag_mismatch("voice_band", 64'(rsp_tdata[6:1]), 64'(want.band));
               if (rsp_tdata[26:7] !== want.level)
                  flag_mismatch("voice_level", 64'(rsp_tdata[26:7]), 64'(want.level));
               if (rsp_tdata[50:27] !== want.phase)
                  flag_mismatch("voice_phase", 64'(rsp_tdata[50:27]), 64'(want.phase));
               if (rsp_tdata[57:51] !== want.live_count)
                  flag_mismatch("live_count", 64'(rsp_tdata[57:51]), 64'(want.live_count));
               if (rsp_tdata[62:58] !== want.spawned)
                  flag_mismatch("spawned_count", 64'(rsp_tdata[62:58]), 64'(want.spawned));
            end
            take_wait = draw_wait(take_run_left, take_run_busy);
         end
         // one long hold-off so the block backs up into its input
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (take_wait > 0) begin
            take_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [FLOOR_W-1:0] amp_plan   [FLOOR_PLANS];
      logic [FLOOR_W-1:0] spawn_plan [FLOOR_PLANS];
      for (int i = 0; i < NUM_VOICES; i++) begin
         voice_on[i]    = 1'b0;
         voice_pos[i]   = 0;
         voice_amp[i]   = '0;
         voice_start[i] = '0;
      end
      for (int k = 0; k < NUM_BANDS; k++) band_peak[k] = '0;
      phase_seed  = LCG_RESET;
      amp_floor   = AMP_FLOOR_RESET;
      spawn_floor = SPAWN_FLOOR_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part under the reset floors
      queue_item(OP_READ, 0, 0, 0, 0, 0);
      queue_item(OP_READ, 0, 0, 0, 0, VINDEX_W'(NUM_VOICES - 1));
      queue_item(OP_TICK, 0, 0, 0, 0, 0);                    // empty bank, zero stride
      queue_item(OP_OFFER, 0, '1, 0, 0, 0);                  // largest level
      queue_item(OP_OFFER, BAND_IN_W'(NUM_BANDS - 1), AMP_W'(SPAWN_FLOOR_RESET - 16'd1),
                 0, 0, 0);
      queue_item(OP_OFFER, BAND_IN_W'(NUM_BANDS - 1), AMP_W'(SPAWN_FLOOR_RESET), 0, 0, 0);
      queue_item(OP_OFFER, BAND_IN_W'(NUM_BANDS - 1), 10, 0, 0, 0); // lower level, peak held
      queue_item(OP_OFFER, 31, 500, 0, 0, 0);                // band past the last one
      queue_item(OP_OFFER, 5, 0, 0, 0, 0);
      queue_item(OP_TICK, 0, 0, 0, TRAIL_W'(TRAIL_MAX), 0);  // pending levels kept
      queue_item(OP_TICK, 0, 0, STRIDE_W'(STRIDE_MAX), TRAIL_W'(TRAIL_MAX), 0);
      queue_item(OP_READ, 0, 0, 0, 0, 0);
      queue_item(OP_READ, 0, 0, 0, 0, 1);
      queue_item(OP_TICK, 0, 0, STRIDE_W'(-2), TRAIL_W'(TRAIL_MAX), 0); // lowest legal band
      queue_item(OP_READ, 0, 0, 0, 0, 0);
      queue_item(OP_TICK, 0, 0, STRIDE_W'(-STRIDE_MAX), TRAIL_W'(TRAIL_MAX), 0); // falls off
      queue_item(OP_OFFER, 2, 1000, 0, 0, 0);
      queue_item(OP_TICK, 0, 0, 1, 0, 0);                    // zero trail kills the rest
      queue_item(OP_READ, 0, 0, 0, 0, 0);
      queue_item(OP_READ, 0, 0, 0, 0, 1);
      queue_item(OP_UNUSED, '1, '1, '1, '1, '1);
      queue_item(OP_OFFER, BAND_IN_W'(NUM_BANDS), 777, 0, 0, 0);
      queue_item(OP_READ, 0, 0, 0, 0, 40);
      wait_until_drained();

      amp_plan   = '{AMP_FLOOR_RESET, 16'd0, 16'hFFFF, 16'($urandom_range(0, 4000)), 16'd0};
      spawn_plan = '{SPAWN_FLOOR_RESET, 16'd0, 16'hFFFF, 16'($urandom), 16'hFFFF};
      for (int p = 0; p < FLOOR_PLANS; p++) begin
         load_floors(amp_plan[p], spawn_plan[p]);
         queue_batch(BATCH_ITEMS);
         if (p == 1) holds_asked++;
         wait_until_drained();
         queue_batch(BATCH_ITEMS);
         wait_until_drained();
      end

      $display("covered %0d offers, %0d ticks, %0d reads, %0d ignored items, %0d floor settings",
               offers_seen, ticks_seen, reads_seen, ignored_seen, FLOOR_PLANS + 1);
      $display("%0d voices spawned, %0d by stealing a slot, at most %0d voices live at once",
               spawned_seen, steals_seen, peak_live);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/dva_pkg.sv
sv/dva_mul.sv
sv/decaying_voice_allocator.sv
dv/tb.sv
